[rtl/fslm_pkg.sv]
`timescale 1ns / 1ps

package fslm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int LINE_BITS   = 32;
    localparam int COLUMN_BITS = 16;
    localparam int REG_BYTES   = 32;

    localparam int MAX_LEN  = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
    localparam int ACT_W    = $clog2(MAX_LEN + 1);
    localparam int FILL_W   = $clog2(MAX_PATTERN + 1);
    localparam int WIN_IW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PAT_IW   = (REG_BYTES > 1) ? $clog2(REG_BYTES) : 1;

    localparam int TEXT_W      = 8;
    localparam int LINE_OUT_W  = 32;
    localparam int COL_OUT_W   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_REG_W   = 6;
    localparam int WORD_BYTES  = CFG_DATA_W / 8;

    localparam logic [TEXT_W-1:0] NEWLINE_BYTE = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] REG_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_LO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_ML = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_MH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_HI = 3'd4;

    typedef logic [REG_BYTES-1:0][7:0]   t_pat;
    typedef logic [MAX_PATTERN-1:0][7:0] t_win;

    typedef struct packed {
        logic [ACT_W-1:0] act_len;
        t_pat             pattern;
    } t_cfg;

    typedef struct packed {
        logic                  hit;
        logic [LINE_OUT_W-1:0] line_number;
        logic [COL_OUT_W-1:0]  match_column;
    } t_report;

endpackage

[rtl/fslm_cfg_regs.sv]
`timescale 1ns / 1ps

module fslm_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [fslm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fslm_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output fslm_pkg::t_cfg                   o_cfg
);

    logic [fslm_pkg::LEN_REG_W-1:0] r_len;
    fslm_pkg::t_pat                 r_pat;
    fslm_pkg::t_pat                 n_pat;
    logic [fslm_pkg::LEN_REG_W-1:0] n_len;

    always_comb begin
        logic [fslm_pkg::PAT_IW-1:0] slot;
        slot  = '0;
        n_len = r_len;
        n_pat = r_pat;
        if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                fslm_pkg::REG_LENGTH: begin
                    n_len = i_cfg_data[fslm_pkg::LEN_REG_W-1:0];
                end
                fslm_pkg::REG_BYTES_LO, fslm_pkg::REG_BYTES_ML,
                fslm_pkg::REG_BYTES_MH, fslm_pkg::REG_BYTES_HI: begin
                    for (int k = 0; k < fslm_pkg::WORD_BYTES; k++) begin
                        slot = fslm_pkg::PAT_IW'((int'(i_cfg_index) - 1)
                             * fslm_pkg::WORD_BYTES + k);
                        n_pat[slot] = i_cfg_data[8*k +: 8];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= fslm_pkg::LEN_REG_W'(1);
            r_pat <= '0;
        end else begin
            r_len <= n_len;
            r_pat <= n_pat;
        end
    end

    always_comb begin
        if (r_len == '0) begin
            o_cfg.act_len = fslm_pkg::ACT_W'(1);
        end else if (int'(r_len) > fslm_pkg::MAX_LEN) begin
            o_cfg.act_len = fslm_pkg::ACT_W'(fslm_pkg::MAX_LEN);
        end else begin
            o_cfg.act_len = fslm_pkg::ACT_W'(r_len);
        end
        o_cfg.pattern = r_pat;
    end

endmodule

[rtl/fslm_window.sv]
`timescale 1ns / 1ps

module fslm_window (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [fslm_pkg::TEXT_W-1:0]   i_text_byte,
    input  logic                          i_file_start,
    input  fslm_pkg::t_cfg                i_cfg,
    output logic                          o_window_hit
);

    fslm_pkg::t_win                   r_win;
    fslm_pkg::t_win                   n_win;
    logic [fslm_pkg::FILL_W-1:0]      r_fill;
    logic [fslm_pkg::FILL_W-1:0]      n_fill;
    logic [fslm_pkg::FILL_W-1:0]      w_fill_base;
    logic                             w_bytes_ok;

    always_comb begin
        n_win[0] = i_text_byte;
        for (int k = 1; k < fslm_pkg::MAX_PATTERN; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    assign w_fill_base = i_file_start ? '0 : r_fill;
    assign n_fill = (int'(w_fill_base) == fslm_pkg::MAX_PATTERN) ? w_fill_base
                  : w_fill_base + fslm_pkg::FILL_W'(1);

    // pattern byte j sits at window slot len-1-j
    always_comb begin
        logic [fslm_pkg::WIN_IW-1:0] idx;
        idx        = '0;
        w_bytes_ok = 1'b1;
        for (int j = 0; j < fslm_pkg::MAX_LEN; j++) begin
            if (j < int'(i_cfg.act_len)) begin
                idx = fslm_pkg::WIN_IW'(int'(i_cfg.act_len) - 1 - j);
                if (i_cfg.pattern[j] != n_win[idx]) begin
                    w_bytes_ok = 1'b0;
                end
            end
        end
    end

    assign o_window_hit = w_bytes_ok && (n_fill >= fslm_pkg::FILL_W'(i_cfg.act_len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_fill <= '0;
        end else if (i_advance) begin
            r_win  <= n_win;
            r_fill <= n_fill;
        end
    end

endmodule

[rtl/fslm_line_track.sv]
`timescale 1ns / 1ps

module fslm_line_track (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [fslm_pkg::TEXT_W-1:0]   i_text_byte,
    input  logic                          i_file_start,
    input  logic                          i_window_hit,
    input  fslm_pkg::t_cfg                i_cfg,
    output fslm_pkg::t_report             o_report
);

    localparam logic [fslm_pkg::LINE_BITS-1:0] LINE_LIMIT =
        {{(fslm_pkg::LINE_BITS-1){1'b1}}, 1'b0};
    localparam logic [fslm_pkg::COLUMN_BITS-1:0] COLUMN_MAX = '1;

    logic [fslm_pkg::LINE_BITS-1:0]   r_line;
    logic [fslm_pkg::COLUMN_BITS-1:0] r_col;
    logic                             r_reported;
    logic [fslm_pkg::LINE_BITS-1:0]   n_line;
    logic [fslm_pkg::COLUMN_BITS-1:0] n_col;
    logic                             n_reported;

    logic [fslm_pkg::LINE_BITS-1:0]   w_line_base;
    logic [fslm_pkg::COLUMN_BITS-1:0] w_col_base;
    logic [fslm_pkg::COLUMN_BITS-1:0] w_back;
    logic [fslm_pkg::COLUMN_BITS-1:0] w_col_out;
    logic                             w_reported_base;
    logic                             w_hit;

    assign w_line_base     = i_file_start ? '0 : r_line;
    assign w_col_base      = i_file_start ? '0 : r_col;
    assign w_reported_base = i_file_start ? 1'b0 : r_reported;
    assign w_hit           = i_window_hit && !w_reported_base;

    assign w_back = fslm_pkg::COLUMN_BITS'(i_cfg.act_len - fslm_pkg::ACT_W'(1));

    always_comb begin
        if (w_col_base >= COLUMN_MAX) begin
            w_col_out = COLUMN_MAX;
        end else if (w_col_base >= w_back) begin
            w_col_out = w_col_base - w_back;
        end else begin
            w_col_out = '0;
        end
    end

    assign o_report.hit          = w_hit;
    assign o_report.line_number  =
        fslm_pkg::LINE_OUT_W'(w_line_base + fslm_pkg::LINE_BITS'(1));
    assign o_report.match_column = fslm_pkg::COL_OUT_W'(w_col_out);

    always_comb begin
        if (i_text_byte == fslm_pkg::NEWLINE_BYTE) begin
            n_line     = (w_line_base < LINE_LIMIT)
                       ? w_line_base + fslm_pkg::LINE_BITS'(1) : w_line_base;
            n_col      = '0;
            n_reported = 1'b0;
        end else begin
            n_line     = w_line_base;
            n_col      = (w_col_base < COLUMN_MAX)
                       ? w_col_base + fslm_pkg::COLUMN_BITS'(1) : w_col_base;
            n_reported = w_reported_base || w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line     <= '0;
            r_col      <= '0;
            r_reported <= 1'b0;
        end else if (i_advance) begin
            r_line     <= n_line;
            r_col      <= n_col;
            r_reported <= n_reported;
        end
    end

endmodule

[rtl/fixed_string_line_matcher.sv]
`timescale 1ns / 1ps

// channel  direction  handshake                    payload
// in       input      i_in_valid / o_in_stall      i_text_byte, i_file_start
// out      output     o_out_valid / i_out_stall    o_line_number, o_match_column
// cfg      input      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while the output is not stalled; a transfer lands
// in the input register and its result, if any, then in the output register.
// The compare over the byte window and the counter update sit between the two.
// Synchronous active-low reset clears window, counters and pattern; length = 1.
// A stalled result holds the output register; the input side keeps taking
// transfers until the input register is also occupied.

module fixed_string_line_matcher (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [fslm_pkg::TEXT_W-1:0]          i_text_byte,
    input  logic                                 i_file_start,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [fslm_pkg::LINE_OUT_W-1:0]      o_line_number,
    output logic [fslm_pkg::COL_OUT_W-1:0]       o_match_column,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [fslm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fslm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic                              r_in_valid;
    logic [fslm_pkg::TEXT_W-1:0]       r_text_byte;
    logic                              r_file_start;
    logic                              r_out_valid;
    logic [fslm_pkg::LINE_OUT_W-1:0]   r_line_number;
    logic [fslm_pkg::COL_OUT_W-1:0]    r_match_column;
    logic                              n_in_valid;

    logic                              w_out_free;
    logic                              w_advance;
    logic                              w_in_take;
    logic                              w_window_hit;
    fslm_pkg::t_cfg                    w_cfg;
    fslm_pkg::t_report                 w_report;

    assign o_cfg_ready = 1'b1;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_in_take  = i_in_valid && !o_in_stall;
    assign n_in_valid = w_in_take || (r_in_valid && !w_advance);

    fslm_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    fslm_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_text_byte  (r_text_byte),
        .i_file_start (r_file_start),
        .i_cfg        (w_cfg),
        .o_window_hit (w_window_hit)
    );

    fslm_line_track u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_text_byte  (r_text_byte),
        .i_file_start (r_file_start),
        .i_window_hit (w_window_hit),
        .i_cfg        (w_cfg),
        .o_report     (w_report)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_text_byte  <= i_text_byte;
            r_file_start <= i_file_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_report.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_report.hit) begin
            r_line_number  <= w_report.line_number;
            r_match_column <= w_report.match_column;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_line_number  = r_line_number;
    assign o_match_column = r_match_column;

endmodule
